// File: rtl/itpa_pkg.sv
// itpa_pkg: types, codes and character constants for the padded integer formatter.
// Used by itpa_digits and integer_to_padded_ascii; depends on nothing.
`default_nettype none

package itpa_pkg;

   // magnitude and digit buffer geometry
   localparam int MAG_W   = 32;
   localparam int NDIG    = 11;             // enough nibbles for 11 octal digits
   localparam int HEX_DIG = 8;
   localparam int NDIG_W  = 4;              // holds 0..NDIG
   localparam logic [4:0] CONV_LAST = 5'(MAG_W - 1);

   // ASCII constants
   localparam logic [6:0] CH_MINUS     = 7'h2D;
   localparam logic [6:0] CH_PLUS      = 7'h2B;
   localparam logic [6:0] CH_SPACE     = 7'h20;
   localparam logic [6:0] CH_ZERO      = 7'h30;
   localparam logic [6:0] CH_ALPHA_OFS = 7'h57;   // 'a' minus ten

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         base_select;
      logic [7:0]         field_width;
      logic               zero_pad;
      logic               show_plus;
      logic               align_left;
   } req_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last_char;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_LEAD,
      ST_SIGN,
      ST_ZERO,
      ST_DIGIT,
      ST_TRAIL
   } state_type;

   typedef enum logic [2:0] {
      DOP_HOLD,
      DOP_LOAD_DEC,
      DOP_LOAD_OCT,
      DOP_LOAD_HEX,
      DOP_DABBLE,
      DOP_SHIFT
   } dig_op_type;

   // command from the sequencer to the digit buffer
   typedef struct packed {
      dig_op_type        op;
      logic [MAG_W-1:0]  mag;
   } dig_ctl_type;

   // ASCII for one digit nibble
   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] r;
      if (d < 4'd10) begin
         r = CH_ZERO + {3'b000, d};
      end else begin
         r = CH_ALPHA_OFS + {3'b000, d};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/itpa_digits.sv
// itpa_digits: nibble-wide digit buffer with bit-serial binary to BCD conversion.
// Depends on itpa_pkg.
`default_nettype none

module itpa_digits (
   input  wire logic                clock,
   input  wire itpa_pkg::dig_ctl_type ctl,
   output logic [3:0]               top_digit
);

   logic [itpa_pkg::NDIG-1:0][3:0]              digits_ff, digits_in;
   logic [itpa_pkg::MAG_W-1:0]                  mag_ff, mag_in;
   logic [itpa_pkg::NDIG-1:0][3:0]              adj;
   logic [itpa_pkg::MAG_W:0]                    mag33;
   logic [itpa_pkg::NDIG*4+itpa_pkg::MAG_W-1:0] dab_w;

   // one operation per cycle: load, double-dabble step or nibble shift
   always_comb begin
      digits_in = digits_ff;
      mag_in    = mag_ff;
      mag33     = {1'b0, ctl.mag};
      for (int i = 0; i < itpa_pkg::NDIG; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      dab_w = {adj, mag_ff} << 1;
      unique case (ctl.op)
         itpa_pkg::DOP_LOAD_DEC: begin
            digits_in = '0;
            mag_in    = ctl.mag;
         end
         itpa_pkg::DOP_LOAD_OCT: begin
            for (int i = 0; i < itpa_pkg::NDIG; i++) begin
               digits_in[i] = {1'b0, mag33[3*i +: 3]};
            end
         end
         itpa_pkg::DOP_LOAD_HEX: begin
            digits_in = '0;
            for (int i = 0; i < itpa_pkg::HEX_DIG; i++) begin
               digits_in[i] = ctl.mag[4*i +: 4];
            end
         end
         itpa_pkg::DOP_DABBLE: begin
            digits_in = dab_w[itpa_pkg::NDIG*4+itpa_pkg::MAG_W-1:itpa_pkg::MAG_W];
            mag_in    = dab_w[itpa_pkg::MAG_W-1:0];
         end
         itpa_pkg::DOP_SHIFT: begin
            digits_in = {digits_ff[itpa_pkg::NDIG-2:0], 4'h0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      mag_ff    <= mag_in;
   end

   assign top_digit = digits_ff[itpa_pkg::NDIG-1];

endmodule

`default_nettype wire

// File: rtl/integer_to_padded_ascii.sv
// integer_to_padded_ascii: printf-style %d/%o/%x formatter, one character per cycle.
// Depends on itpa_pkg and itpa_digits.
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_data       in         taken when start & !busy
//   result    rsp_strobe, rsp_data        out        one cycle per character
//
// The accepting edge loads the digit buffer. Decimal then runs bit-serial BCD
// conversion in the digit buffer; every base then drops leading zero digits,
// keeping at least one, and sends its 1 to FIELD_CHARS-1 characters one at a
// time through the single character port.
// busy is high from the accepting edge until the last character has gone.
// Reset is synchronous and idles the sequencer; the receiver never stalls.
`default_nettype none

module integer_to_padded_ascii #(
   parameter int FIELD_CHARS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire itpa_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output itpa_pkg::rsp_type      rsp_data
);

   localparam int PW = $clog2(FIELD_CHARS);
   localparam logic [7:0] WMAX = 8'(FIELD_CHARS - 1);

   itpa_pkg::state_type        state_ff, state_in;
   logic [itpa_pkg::NDIG_W-1:0] ndig_ff, ndig_in;
   logic [PW-1:0]              pad_ff, pad_in;
   logic [PW-1:0]              width_ff, width_in;
   logic [4:0]                 cyc_ff, cyc_in;
   logic                       neg_ff, neg_in;
   logic                       sign_ff, sign_in;
   logic                       left_ff, left_in;
   logic                       zero_ff, zero_in;

   itpa_pkg::dig_ctl_type      ctl;
   logic [3:0]                 top_digit;
   logic [itpa_pkg::MAG_W-1:0] mag_w;
   logic [PW-1:0]              text_len_w;
   logic [PW-1:0]              pad_w;
   logic                       trim_done;
   logic                       accept;

   assign busy   = (state_ff != itpa_pkg::ST_IDLE);
   assign accept = start && !busy;

   // magnitude of the request value; the most negative value wraps to 2^31
   assign mag_w = req_data.value[31] ? (32'd0 - $unsigned(req_data.value))
                                     : $unsigned(req_data.value);

   // padding needed once the digit count is final
   assign text_len_w = PW'(ndig_ff) + PW'(sign_ff);
   assign pad_w      = (width_ff > text_len_w) ? width_ff - text_len_w : '0;
   assign trim_done  = (top_digit != 4'h0) || (ndig_ff == itpa_pkg::NDIG_W'(1));

   itpa_digits u_digits (
      .clock     (clock),
      .ctl       (ctl),
      .top_digit (top_digit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itpa_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.base_select == itpa_pkg::BASE_OCT ||
                   req_data.base_select == itpa_pkg::BASE_HEX) begin
                  state_in = itpa_pkg::ST_TRIM;
               end else begin
                  state_in = itpa_pkg::ST_CONVERT;
               end
            end
         end
         itpa_pkg::ST_CONVERT: begin
            if (cyc_ff == itpa_pkg::CONV_LAST) state_in = itpa_pkg::ST_TRIM;
         end
         itpa_pkg::ST_TRIM: begin
            if (trim_done) begin
               if (left_ff || zero_ff) begin
                  if (sign_ff)               state_in = itpa_pkg::ST_SIGN;
                  else if (zero_ff && pad_w != '0) state_in = itpa_pkg::ST_ZERO;
                  else                       state_in = itpa_pkg::ST_DIGIT;
               end else if (pad_w != '0) begin
                  state_in = itpa_pkg::ST_LEAD;
               end else begin
                  state_in = sign_ff ? itpa_pkg::ST_SIGN : itpa_pkg::ST_DIGIT;
               end
            end
         end
         itpa_pkg::ST_LEAD: begin
            if (pad_ff == PW'(1)) begin
               state_in = sign_ff ? itpa_pkg::ST_SIGN : itpa_pkg::ST_DIGIT;
            end
         end
         itpa_pkg::ST_SIGN: begin
            state_in = (zero_ff && pad_ff != '0) ? itpa_pkg::ST_ZERO : itpa_pkg::ST_DIGIT;
         end
         itpa_pkg::ST_ZERO: begin
            if (pad_ff == PW'(1)) state_in = itpa_pkg::ST_DIGIT;
         end
         itpa_pkg::ST_DIGIT: begin
            if (ndig_ff == itpa_pkg::NDIG_W'(1)) begin
               state_in = (left_ff && pad_ff != '0) ? itpa_pkg::ST_TRAIL : itpa_pkg::ST_IDLE;
            end
         end
         itpa_pkg::ST_TRAIL: begin
            if (pad_ff == PW'(1)) state_in = itpa_pkg::ST_IDLE;
         end
         default: state_in = itpa_pkg::ST_IDLE;
      endcase
   end

   // outputs, digit buffer commands and counter updates
   always_comb begin
      ctl.op             = itpa_pkg::DOP_HOLD;
      ctl.mag            = mag_w;
      rsp_strobe         = 1'b0;
      rsp_data.character = itpa_pkg::CH_SPACE;
      rsp_data.last_char = 1'b0;
      ndig_in            = ndig_ff;
      pad_in             = pad_ff;
      width_in           = width_ff;
      cyc_in             = cyc_ff;
      neg_in             = neg_ff;
      sign_in            = sign_ff;
      left_in            = left_ff;
      zero_in            = zero_ff;
      unique case (state_ff)
         itpa_pkg::ST_IDLE: begin
            if (start) begin
               neg_in   = req_data.value[31];
               sign_in  = req_data.value[31] || req_data.show_plus;
               left_in  = req_data.align_left;
               zero_in  = req_data.zero_pad && !req_data.align_left;
               width_in = PW'((req_data.field_width > WMAX) ? WMAX : req_data.field_width);
               ndig_in  = itpa_pkg::NDIG_W'(itpa_pkg::NDIG);
               cyc_in   = '0;
               pad_in   = '0;
               if (req_data.base_select == itpa_pkg::BASE_OCT) begin
                  ctl.op = itpa_pkg::DOP_LOAD_OCT;
               end else if (req_data.base_select == itpa_pkg::BASE_HEX) begin
                  ctl.op = itpa_pkg::DOP_LOAD_HEX;
               end else begin
                  ctl.op = itpa_pkg::DOP_LOAD_DEC;
               end
            end
         end
         itpa_pkg::ST_CONVERT: begin
            ctl.op = itpa_pkg::DOP_DABBLE;
            cyc_in = cyc_ff + 5'd1;
         end
         itpa_pkg::ST_TRIM: begin
            // drop leading zero digits, keeping at least one
            if (!trim_done) begin
               ctl.op  = itpa_pkg::DOP_SHIFT;
               ndig_in = ndig_ff - itpa_pkg::NDIG_W'(1);
            end else begin
               pad_in = pad_w;
            end
         end
         itpa_pkg::ST_LEAD: begin
            rsp_strobe         = 1'b1;
            rsp_data.character = itpa_pkg::CH_SPACE;
            pad_in             = pad_ff - PW'(1);
         end
         itpa_pkg::ST_SIGN: begin
            rsp_strobe         = 1'b1;
            rsp_data.character = neg_ff ? itpa_pkg::CH_MINUS : itpa_pkg::CH_PLUS;
         end
         itpa_pkg::ST_ZERO: begin
            rsp_strobe         = 1'b1;
            rsp_data.character = itpa_pkg::CH_ZERO;
            pad_in             = pad_ff - PW'(1);
         end
         itpa_pkg::ST_DIGIT: begin
            rsp_strobe         = 1'b1;
            rsp_data.character = itpa_pkg::digit_char(top_digit);
            rsp_data.last_char = (ndig_ff == itpa_pkg::NDIG_W'(1)) &&
                                 !(left_ff && pad_ff != '0);
            ctl.op             = itpa_pkg::DOP_SHIFT;
            ndig_in            = ndig_ff - itpa_pkg::NDIG_W'(1);
         end
         itpa_pkg::ST_TRAIL: begin
            rsp_strobe         = 1'b1;
            rsp_data.character = itpa_pkg::CH_SPACE;
            rsp_data.last_char = (pad_ff == PW'(1));
            pad_in             = pad_ff - PW'(1);
         end
         default: begin
         end
      endcase
   end

   // sequencer and request registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itpa_pkg::ST_IDLE;
         ndig_ff  <= '0;
         pad_ff   <= '0;
         cyc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ndig_ff  <= ndig_in;
         pad_ff   <= pad_in;
         cyc_ff   <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      neg_ff   <= neg_in;
      sign_ff  <= sign_in;
      left_ff  <= left_in;
      zero_ff  <= zero_in;
   end

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_char |=> !busy)
      else $error("busy still high after last character");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_strobe)
      else $error("character strobed while idle");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == itpa_pkg::ST_DIGIT |-> ndig_ff != '0)
      else $error("digit emitted with empty digit count");

endmodule

`default_nettype wire
